// File: rtl/gdda_pkg.sv
// Shared types, constants and calendar tables for the Gregorian date day-arithmetic block.
package gdda_pkg;

    // Field widths
    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 17;
    localparam int DIFF_W  = 23;
    localparam int SER_W   = 23;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;

    // Stream word widths
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 56;

    // Calendar range
    localparam int MAX_YEAR = 9999;
    localparam logic [YEAR_W-1:0]  DEFAULT_YEAR  = 14'd1900;
    localparam logic [MONTH_W-1:0] DEFAULT_MONTH = 4'd1;
    localparam logic [DAY_W-1:0]   DEFAULT_DAY   = 5'd1;

    // floor(p / 100) == (p * DIV100_RECIP) >> DIV100_SHIFT for all 14-bit p
    localparam logic [12:0] DIV100_RECIP = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    // Days in 400, 100, 4 and 1 year spans
    localparam logic [SER_W-1:0] DAYS_400 = 23'd146097;
    localparam logic [SER_W-1:0] DAYS_100 = 23'd36524;
    localparam logic [SER_W-1:0] DAYS_4   = 23'd1461;
    localparam logic [SER_W-1:0] DAYS_1   = 23'd365;

    // Day number of the last representable date, with 0001-01-01 as day 0
    localparam int MAX_LEAP = (((MAX_YEAR % 4) == 0) && ((MAX_YEAR % 100) != 0))
                              || ((MAX_YEAR % 400) == 0) ? 1 : 0;
    localparam int TOP_SERIAL = 365 * (MAX_YEAR - 1) + (MAX_YEAR - 1) / 4
                                - (MAX_YEAR - 1) / 100 + (MAX_YEAR - 1) / 400
                                + 364 + MAX_LEAP;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD,
        OP_ADD,
        OP_SUB,
        OP_CMP
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK,
        STAT_INVALID,
        STAT_RANGE
    } stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_YDIV,
        ST_YSUM,
        ST_DSUM,
        ST_EVAL,
        ST_RANGE,
        ST_D400,
        ST_D100,
        ST_D4,
        ST_D1,
        ST_YBLD,
        ST_MON,
        ST_DONE
    } state_t;

    // Length of a month; 0 for a code that is no month
    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before the first of a month in a common year
    function automatic logic [8:0] cum_days(input logic [MONTH_W-1:0] m);
        logic [8:0] days;
        case (m)
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

// File: rtl/gregorian_date_day_arithmetic.sv
// Gregorian date unit: load, add/subtract days and compare, under a small sequencer.
//
//   channel | dir | tdata                                   | tuser
//   s_      | in  | day_count, given_year, month, day (40b) | opcode (2b)
//   m_      | out | cur date, day_difference, flags (56b)   | status (2b)
//
// Load runs the day number pass once; compare runs it twice, for the given date
// and then the stored date. Add and subtract split the day number back into a
// date by repeated subtraction of 400/100/4/1-year spans and month lengths,
// one step per cycle through a single shared subtractor.
// Reset (aresetn low at a clock edge) sets the date to 1900-01-01.
// s_tready is high only while no word is in work; a finished result waits in
// the output register under m_tready stall while the next word is taken.
module gregorian_date_day_arithmetic (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [16:0] day_count, [30:17] given_year, [34:31] given_month, [39:35] given_day
    input  logic [gdda_pkg::IN_DATA_W-1:0]     s_tdata,
    // [1:0] opcode
    input  logic [gdda_pkg::OP_W-1:0]          s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [13:0] cur_year, [17:14] cur_month, [22:18] cur_day, [45:23] day_difference,
    // [46] is_greater, [47] is_equal, [48] is_less, [55:49] zero
    output logic [gdda_pkg::OUT_DATA_W-1:0]    m_tdata,
    // [1:0] status
    output logic [gdda_pkg::STAT_W-1:0]        m_tuser
);
    import gdda_pkg::*;

    state_t state_reg, state_next;

    // Stored date
    logic [YEAR_W-1:0]  cur_year_reg;
    logic [MONTH_W-1:0] cur_month_reg;
    logic [DAY_W-1:0]   cur_day_reg;

    // Accepted word
    op_t                        op_reg;
    logic signed [COUNT_W-1:0]  cnt_reg;
    logic [YEAR_W-1:0]          gy_reg;
    logic [MONTH_W-1:0]         gm_reg;
    logic [DAY_W-1:0]           gd_reg;
    logic                       use_cur_reg;
    logic                       pass_reg;

    // Day number datapath
    logic [7:0]                 q100_reg;
    logic [SER_W-1:0]           ypart_reg;
    logic                       leap_reg;
    logic [SER_W-1:0]           ser_reg;
    logic [SER_W-1:0]           gser_reg;
    logic                       valid_reg;
    logic signed [SER_W+1:0]    sum_reg;

    // Date split datapath
    logic [SER_W-1:0]           n_reg;
    logic [5:0]                 q400_reg;
    logic [1:0]                 cent_reg;
    logic [4:0]                 quad_reg;
    logic [1:0]                 yrs_reg;
    logic [YEAR_W-1:0]          yy_reg;
    logic [MONTH_W-1:0]         mm_reg;

    // Result
    stat_t                      status_reg;
    logic [DIFF_W-1:0]          diff_reg;
    logic                       gt_reg;
    logic                       eq_reg;
    logic                       lt_reg;

    // Output register
    logic                       m_valid_reg;
    logic [OUT_DATA_W-1:0]      m_data_reg;
    logic [STAT_W-1:0]          m_user_reg;

    // Operand date for the day number pass
    logic [YEAR_W-1:0]  yr;
    logic [MONTH_W-1:0] mo;
    logic [DAY_W-1:0]   dy;
    logic [YEAR_W-1:0]  p;
    logic [26:0]        prod;
    logic [YEAR_W-1:0]  rem100;
    logic               leap_y;
    logic [SER_W-1:0]   ypart_calc;
    logic [SER_W-1:0]   ser_calc;
    logic               valid_calc;

    assign yr = use_cur_reg ? cur_year_reg  : gy_reg;
    assign mo = use_cur_reg ? cur_month_reg : gm_reg;
    assign dy = use_cur_reg ? cur_day_reg   : gd_reg;
    assign p  = yr - 14'd1;

    // Year part of the day number: 365p + p/4 - p/100 + p/400
    assign prod       = 27'(p) * 27'(DIV100_RECIP);
    assign rem100     = p - 14'(q100_reg) * 14'd100;
    assign leap_y     = (rem100 == 14'd99) ? (q100_reg[1:0] == 2'd3) : (p[1:0] == 2'd3);
    assign ypart_calc = 23'(p) * 23'd365 + 23'(p[13:2]) - 23'(q100_reg)
                        + 23'(q100_reg[7:2]);

    // Month and day part, and date check
    assign ser_calc   = ypart_reg + 23'(cum_days(mo)) + 23'((mo > 4'd2) && leap_reg)
                        + 23'(dy) - 23'd1;
    assign valid_calc = (yr != 14'd0) && (yr <= 14'(MAX_YEAR))
                        && (mo >= 4'd1) && (mo <= 4'd12)
                        && (dy != 5'd0) && (dy <= month_len(leap_reg, mo));

    // Add/subtract and compare arithmetic
    logic signed [SER_W+1:0] cnt_ext;
    logic signed [SER_W+1:0] sum_calc;
    logic                    range_bad;
    logic signed [SER_W:0]   dwide;

    assign cnt_ext   = 25'(cnt_reg);
    assign sum_calc  = $signed({2'b00, ser_reg}) + ((op_reg == OP_SUB) ? -cnt_ext : cnt_ext);
    assign range_bad = sum_reg[SER_W+1] || (sum_reg[SER_W:0] > 24'(TOP_SERIAL));
    assign dwide     = $signed({1'b0, ser_reg}) - $signed({1'b0, gser_reg});

    // Shared subtractor for the date split
    logic [SER_W-1:0] sub_b;
    logic [SER_W:0]   sub_res;
    logic             fits;
    logic             step_go;

    always_comb begin
        case (state_reg)
            ST_D400: sub_b = DAYS_400;
            ST_D100: sub_b = DAYS_100;
            ST_D4:   sub_b = DAYS_4;
            ST_D1:   sub_b = DAYS_1;
            ST_MON:  sub_b = 23'(month_len(leap_reg, mm_reg));
            default: sub_b = '0;
        endcase
    end

    assign sub_res = {1'b0, n_reg} - {1'b0, sub_b};
    assign fits    = !sub_res[SER_W];

    always_comb begin
        case (state_reg)
            ST_D400: step_go = fits;
            ST_D100: step_go = fits && (cent_reg != 2'd3);
            ST_D4:   step_go = fits;
            ST_D1:   step_go = fits && (yrs_reg != 2'd3);
            ST_MON:  step_go = fits && (mm_reg < 4'd12);
            default: step_go = 1'b0;
        endcase
    end

    // Handshake controls
    logic s_fire;
    logic out_load;

    always_comb begin
        s_tready = (state_reg == ST_IDLE);
        out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);
    end

    assign s_fire = s_tvalid && s_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = ST_YDIV;
            ST_YDIV:  state_next = ST_YSUM;
            ST_YSUM:  state_next = ST_DSUM;
            ST_DSUM:  state_next = ST_EVAL;
            ST_EVAL: begin
                unique case (op_reg) inside
                    OP_ADD, OP_SUB: state_next = ST_RANGE;
                    OP_CMP:         state_next = (!pass_reg && valid_reg) ? ST_YDIV : ST_DONE;
                    default:        state_next = ST_DONE;
                endcase
            end
            ST_RANGE: state_next = range_bad ? ST_DONE : ST_D400;
            ST_D400:  if (!step_go) state_next = ST_D100;
            ST_D100:  if (!step_go) state_next = ST_D4;
            ST_D4:    if (!step_go) state_next = ST_D1;
            ST_D1:    if (!step_go) state_next = ST_YBLD;
            ST_YBLD:  state_next = ST_MON;
            ST_MON:   if (!step_go) state_next = ST_DONE;
            ST_DONE:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Stored date and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_year_reg  <= DEFAULT_YEAR;
            cur_month_reg <= DEFAULT_MONTH;
            cur_day_reg   <= DEFAULT_DAY;
            m_valid_reg   <= 1'b0;
        end else begin
            if (state_reg == ST_EVAL && op_reg == OP_LOAD) begin
                if (valid_reg) begin
                    cur_year_reg  <= gy_reg;
                    cur_month_reg <= gm_reg;
                    cur_day_reg   <= gd_reg;
                end else begin
                    cur_year_reg  <= DEFAULT_YEAR;
                    cur_month_reg <= DEFAULT_MONTH;
                    cur_day_reg   <= DEFAULT_DAY;
                end
            end
            if (state_reg == ST_MON && !step_go) begin
                cur_year_reg  <= yy_reg;
                cur_month_reg <= mm_reg;
                cur_day_reg   <= 5'(n_reg) + 5'd1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Sequenced datapath
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg      <= op_t'(s_tuser);
            cnt_reg     <= s_tdata[16:0];
            gy_reg      <= s_tdata[30:17];
            gm_reg      <= s_tdata[34:31];
            gd_reg      <= s_tdata[39:35];
            use_cur_reg <= (op_t'(s_tuser) == OP_ADD) || (op_t'(s_tuser) == OP_SUB);
            pass_reg    <= 1'b0;
            status_reg  <= STAT_OK;
            diff_reg    <= '0;
            gt_reg      <= 1'b0;
            eq_reg      <= 1'b0;
            lt_reg      <= 1'b0;
        end

        case (state_reg)
            ST_YDIV: q100_reg <= prod[26:DIV100_SHIFT];
            ST_YSUM: begin
                ypart_reg <= ypart_calc;
                leap_reg  <= leap_y;
            end
            ST_DSUM: begin
                ser_reg   <= ser_calc;
                valid_reg <= valid_calc;
            end
            ST_EVAL: begin
                case (op_reg) inside
                    OP_LOAD: begin
                        if (!valid_reg) status_reg <= STAT_INVALID;
                    end
                    OP_ADD, OP_SUB: sum_reg <= sum_calc;
                    default: begin
                        if (!pass_reg) begin
                            // keep the given day number, then run the stored date
                            if (!valid_reg) begin
                                status_reg <= STAT_INVALID;
                            end else begin
                                gser_reg    <= ser_reg;
                                pass_reg    <= 1'b1;
                                use_cur_reg <= 1'b1;
                            end
                        end else begin
                            gt_reg <= !dwide[SER_W] && (dwide != '0);
                            eq_reg <= (dwide == '0);
                            lt_reg <= dwide[SER_W];
                            if (!dwide[SER_W] && dwide[SER_W-1]) begin
                                diff_reg <= {1'b0, {(DIFF_W-1){1'b1}}};
                            end else if (dwide[SER_W] && !dwide[SER_W-1]) begin
                                diff_reg <= {1'b1, {(DIFF_W-1){1'b0}}};
                            end else begin
                                diff_reg <= dwide[DIFF_W-1:0];
                            end
                        end
                    end
                endcase
            end
            ST_RANGE: begin
                if (range_bad) begin
                    status_reg <= STAT_RANGE;
                end else begin
                    n_reg    <= sum_reg[SER_W-1:0];
                    q400_reg <= '0;
                    cent_reg <= '0;
                    quad_reg <= '0;
                    yrs_reg  <= '0;
                end
            end
            ST_D400: if (step_go) begin
                n_reg    <= sub_res[SER_W-1:0];
                q400_reg <= q400_reg + 6'd1;
            end
            ST_D100: if (step_go) begin
                n_reg    <= sub_res[SER_W-1:0];
                cent_reg <= cent_reg + 2'd1;
            end
            ST_D4: if (step_go) begin
                n_reg    <= sub_res[SER_W-1:0];
                quad_reg <= quad_reg + 5'd1;
            end
            ST_D1: if (step_go) begin
                n_reg   <= sub_res[SER_W-1:0];
                yrs_reg <= yrs_reg + 2'd1;
            end
            ST_YBLD: begin
                // rebuild the year and its leap flag from the span counts
                yy_reg   <= 14'(q400_reg) * 14'd400 + 14'(cent_reg) * 14'd100
                            + 14'(quad_reg) * 14'd4 + 14'(yrs_reg) + 14'd1;
                leap_reg <= (yrs_reg == 2'd3) && !((quad_reg == 5'd24) && (cent_reg != 2'd3));
                mm_reg   <= 4'd1;
            end
            ST_MON: if (step_go) begin
                n_reg  <= sub_res[SER_W-1:0];
                mm_reg <= mm_reg + 4'd1;
            end
            default: ;
        endcase

        // Capture the result word
        if (out_load) begin
            m_data_reg <= {7'd0, lt_reg, eq_reg, gt_reg, diff_reg,
                           cur_day_reg, cur_month_reg, cur_year_reg};
            m_user_reg <= status_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // Stored date keeps a nonzero year, a month of 1 to 12 and a nonzero day
    a_date_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_year_reg != 14'd0) && (cur_month_reg >= 4'd1) && (cur_month_reg <= 4'd12)
        && (cur_day_reg != 5'd0))
        else $error("stored date left the valid range");

    // One word in work at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again while a word is in work");

    // Result register is only filled from the finishing step
    a_out_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result word raised outside the finishing step");

    // Month stepping starts with less than one year of days left
    a_month_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MON) |-> (n_reg < 23'd366) && (mm_reg >= 4'd1) && (mm_reg <= 4'd12))
        else $error("month stepping out of range");

endmodule
